### src/rmac_pkg.sv
// ----------------------------------------------------------------------------
// Range map package
// Shared constants, register indexes and the square-root table for exp2.
// ----------------------------------------------------------------------------
package rmac_pkg;

  // Number of log2 squaring steps and exp2 root steps, clamped to 32.
  localparam int CURVE_ITERATIONS = 16;
  localparam int ITER_COUNT = (CURVE_ITERATIONS > 32) ? 32 : CURVE_ITERATIONS;
  localparam int ITW = (ITER_COUNT > 1) ? $clog2(ITER_COUNT) : 1;

  // Configuration register indexes.
  localparam logic [2:0] REG_IN_LOW    = 3'd0;
  localparam logic [2:0] REG_IN_HIGH   = 3'd1;
  localparam logic [2:0] REG_OUT_LOW   = 3'd2;
  localparam logic [2:0] REG_OUT_HIGH  = 3'd3;
  localparam logic [2:0] REG_CURVE_EXP = 3'd4;

  // Operation codes.
  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // One in Q1.30.
  localparam logic [30:0] Q_ONE = 31'h4000_0000;

  typedef logic [30:0] ctab_t [ITER_COUNT];

  // Integer square root, evaluated only at elaboration.
  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] nn;
    logic [63:0] res;
    logic [63:0] b;
    nn  = n;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (nn >= res + b) begin
        nn  = nn - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Successive square roots of one half in Q1.30.
  function automatic ctab_t calc_ctab();
    ctab_t       tab;
    logic [63:0] c;
    c = 64'h2000_0000;
    for (int i = 0; i < ITER_COUNT; i++) begin
      c      = isqrt64(c << 30);
      tab[i] = c[30:0];
    end
    return tab;
  endfunction

  localparam ctab_t C_TAB = calc_ctab();

endpackage

### src/rmac_if.sv
// ----------------------------------------------------------------------------
// Range map channels
// Valid/ready channels for the input words and the result words.
// ----------------------------------------------------------------------------
interface rmac_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] sample;
  modport source (output valid, op, sample, input ready);
  modport sink (input valid, op, sample, output ready);
endinterface

interface rmac_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mapped;
  logic signed [31:0] learned_low;
  logic signed [31:0] learned_high;
  logic               low_dropped;
  logic               high_rose;
  logic               learned_valid;
  logic               learning_on;
  modport source (output valid, mapped, learned_low, learned_high, low_dropped,
                  high_rose, learned_valid, learning_on, input ready);
  modport sink (input valid, mapped, learned_low, learned_high, low_dropped,
                high_rose, learned_valid, learning_on, output ready);
endinterface

### src/range_map_autorange_curve.sv
// ----------------------------------------------------------------------------
// Range map with range learning and power curve
// Maps Q16.16 samples from an input range to an output range.
// ----------------------------------------------------------------------------
// The input channel in_ch carries an op and a sample; every accepted word
// gives exactly one result word on out_ch. Op 0 maps the sample, op 1 starts
// range learning, op 2 stops it. Registers are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while the block
// is idle, as the block itself does not enforce this. One word is processed
// at a time and in_ch.ready is high only when the sequencer is idle. A map
// op may run the 30-step divider; a curved map also runs the normalize,
// log2 squaring and exp2 root steps, and the shared multiplier is used by
// each log2 and exp2 step. The result sits in an output register; if the
// receiver stalls, the next word may still be accepted and computed, and it
// waits in the last sequencer state until the output register is free.
// Reset puts the registers at their defaults, learning off, tracks at their
// extremes and no result pending.
// ----------------------------------------------------------------------------
module range_map_autorange_curve (
  input  logic                clk,
  input  logic                rst_n,
  rmac_in_if.sink             in_ch,
  rmac_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import rmac_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_CLASS, S_DIV, S_CURVE, S_NORMLZ, S_LOG, S_TMUL,
    S_EXP, S_SHR, S_POWFIN, S_PROD, S_SUM, S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic signed [31:0] in_low_r, in_high_r, out_low_r, out_high_r;
  logic signed [15:0] curve_exp_r;

  // Learning state.
  logic               learning_r;
  logic signed [31:0] track_low_r, track_high_r;

  // Work registers.
  logic [1:0]         op_r;
  logic               dropped_r, rose_r;
  logic signed [31:0] v_r, lo_r, hi_r;
  logic signed [32:0] d_r, span_r;
  logic [33:0]        rem_r;
  logic [32:0]        div_r;
  logic [29:0]        q_r;
  logic [4:0]         cnt_r;
  logic [30:0]        norm_r;
  logic               neg_r;
  logic [15:0]        mag_r;
  logic [31:0]        m_r;
  logic [5:0]         k_r;
  logic [31:0]        frac_r;
  logic [ITW-1:0]     it_r;
  logic [31:0]        f_r;
  logic [4:0]         ip_r;
  logic [30:0]        res_r;
  logic [30:0]        px_r;
  logic [30:0]        curved_r;
  logic signed [33:0] qv_r;
  logic signed [31:0] mapped_res_r;

  // Output register.
  logic               out_valid_r;
  logic signed [31:0] out_mapped_r, out_low_rr, out_high_rr;
  logic               out_drop_r, out_rose_r, out_lvalid_r, out_lon_r;

  // Shared multiplier.
  logic [36:0] mul_a;
  logic [30:0] mul_b;
  logic [67:0] mul_p;

  logic signed [32:0] diff;
  logic [32:0]        abs_diff;
  logic [36:0]        nl;

  assign diff     = 33'(out_high_r) - 33'(out_low_r);
  assign abs_diff = diff[32] ? 33'(-diff) : 33'(diff);
  assign nl       = {k_r[4:0], 32'd0} - {5'd0, frac_r};

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LOG: begin
        mul_a = {5'd0, m_r};
        mul_b = m_r[30:0];
      end
      S_TMUL: begin
        mul_a = nl;
        mul_b = {15'd0, mag_r};
      end
      S_EXP: begin
        mul_a = {6'd0, res_r};
        mul_b = C_TAB[it_r];
      end
      S_PROD: begin
        mul_a = {4'd0, abs_diff};
        mul_b = curved_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = 68'(mul_a) * 68'(mul_b);

  // Step signals.
  logic [33:0]        rem2;
  logic [31:0]        sq;
  logic [44:0]        tval;
  logic signed [34:0] sum;
  logic               lin;
  logic [32:0]        ad, as_v;

  assign rem2 = {rem_r[32:0], 1'b0};
  assign sq   = mul_p[61:30];
  assign tval = mul_p[52:8];
  assign sum  = 35'(out_low_r) + 35'(qv_r);
  assign lin  = (curve_exp_r == 16'sd0) || (curve_exp_r == 16'sd256) ||
                (curve_exp_r == -16'sd256);
  assign ad   = d_r[32] ? 33'(-d_r) : 33'(d_r);
  assign as_v = span_r[32] ? 33'(-span_r) : 33'(span_r);

  assign in_ch.ready = (state_r == S_IDLE);

  // Sequencer with configuration and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_low_r     <= -32'sd65536;
      in_high_r    <= 32'sd65536;
      out_low_r    <= 32'sd0;
      out_high_r   <= 32'sd65536;
      curve_exp_r  <= 16'sd256;
      learning_r   <= 1'b0;
      track_low_r  <= 32'sh7FFF_FFFF;
      track_high_r <= 32'sh8000_0000;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IN_LOW:    in_low_r    <= cfg_wdata;
          REG_IN_HIGH:   in_high_r   <= cfg_wdata;
          REG_OUT_LOW:   out_low_r   <= cfg_wdata;
          REG_OUT_HIGH:  out_high_r  <= cfg_wdata;
          REG_CURVE_EXP: curve_exp_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r         <= in_ch.op;
            v_r          <= in_ch.sample;
            dropped_r    <= 1'b0;
            rose_r       <= 1'b0;
            mapped_res_r <= '0;
            lo_r         <= in_low_r;
            hi_r         <= in_high_r;
            state_r      <= S_DONE;
            case (in_ch.op)
              OP_MAP: begin
                state_r <= S_SETUP;
                if (learning_r) begin
                  lo_r <= track_low_r;
                  hi_r <= track_high_r;
                  if (in_ch.sample > track_high_r) begin
                    track_high_r <= in_ch.sample;
                    hi_r         <= in_ch.sample;
                    rose_r       <= 1'b1;
                  end
                  if (in_ch.sample < track_low_r) begin
                    track_low_r <= in_ch.sample;
                    lo_r        <= in_ch.sample;
                    dropped_r   <= 1'b1;
                  end
                end
              end
              OP_START: begin
                learning_r   <= 1'b1;
                track_low_r  <= 32'sh7FFF_FFFF;
                track_high_r <= 32'sh8000_0000;
              end
              OP_STOP: learning_r <= 1'b0;
              default: ;
            endcase
          end
        end
        S_SETUP: begin
          d_r     <= 33'(v_r) - 33'(lo_r);
          span_r  <= 33'(hi_r) - 33'(lo_r);
          state_r <= S_CLASS;
        end
        S_CLASS: begin
          state_r <= S_CURVE;
          cnt_r   <= '0;
          if (span_r == 33'sd0) begin
            norm_r <= Q_ONE >> 1;
          end else if (d_r == 33'sd0 || (d_r[32] != span_r[32])) begin
            norm_r <= '0;
          end else if (ad >= as_v) begin
            norm_r <= Q_ONE;
          end else begin
            rem_r   <= {1'b0, ad};
            div_r   <= as_v;
            q_r     <= '0;
            state_r <= S_DIV;
          end
        end
        // One quotient bit per cycle.
        S_DIV: begin
          if (rem2 >= {1'b0, div_r}) begin
            rem_r <= rem2 - {1'b0, div_r};
            q_r   <= {q_r[28:0], 1'b1};
          end else begin
            rem_r <= rem2;
            q_r   <= {q_r[28:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd29) begin
            state_r <= S_CURVE;
          end
        end
        S_CURVE: begin
          logic [30:0] nv;
          logic [30:0] x;
          nv = (state_r == S_CURVE && cnt_r == 5'd30) ? {1'b0, q_r} : norm_r;
          x  = curve_exp_r[15] ? (Q_ONE - nv) : nv;
          norm_r <= nv;
          cnt_r  <= '0;
          neg_r  <= curve_exp_r[15];
          mag_r  <= curve_exp_r[15] ? 16'(-curve_exp_r) : 16'(curve_exp_r);
          if (lin) begin
            curved_r <= nv;
            state_r  <= S_PROD;
          end else if (x == '0) begin
            px_r    <= '0;
            state_r <= S_POWFIN;
          end else if (x >= Q_ONE) begin
            px_r    <= Q_ONE;
            state_r <= S_POWFIN;
          end else begin
            m_r     <= {1'b0, x};
            k_r     <= '0;
            state_r <= S_NORMLZ;
          end
        end
        // Shift one place per cycle until the value reaches one.
        S_NORMLZ: begin
          if (m_r < {1'b0, Q_ONE}) begin
            m_r <= m_r << 1;
            k_r <= k_r + 6'd1;
          end else begin
            frac_r  <= '0;
            it_r    <= '0;
            state_r <= S_LOG;
          end
        end
        // One log2 fraction bit per squaring.
        S_LOG: begin
          if (sq[31]) begin
            m_r    <= sq >> 1;
            frac_r <= frac_r | (32'h8000_0000 >> it_r);
          end else begin
            m_r <= sq;
          end
          it_r <= it_r + ITW'(1);
          if (it_r == ITW'(ITER_COUNT - 1)) begin
            state_r <= S_TMUL;
          end
        end
        S_TMUL: begin
          f_r   <= tval[31:0];
          ip_r  <= tval[36:32];
          res_r <= Q_ONE;
          it_r  <= '0;
          if (tval[44:32] > 13'd30) begin
            px_r    <= '0;
            state_r <= S_POWFIN;
          end else begin
            state_r <= S_EXP;
          end
        end
        // One root factor per cycle for each set fraction bit.
        S_EXP: begin
          if (f_r[31]) begin
            res_r <= mul_p[60:30];
          end
          f_r  <= f_r << 1;
          it_r <= it_r + ITW'(1);
          if (it_r == ITW'(ITER_COUNT - 1)) begin
            state_r <= S_SHR;
          end
        end
        S_SHR: begin
          px_r    <= res_r >> ip_r;
          state_r <= S_POWFIN;
        end
        S_POWFIN: begin
          curved_r <= neg_r ? (Q_ONE - px_r) : px_r;
          state_r  <= S_PROD;
        end
        S_PROD: begin
          qv_r    <= diff[32] ? -34'($signed({1'b0, mul_p[62:30]}))
                              : 34'($signed({1'b0, mul_p[62:30]}));
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (sum > 35'sh0_7FFF_FFFF) begin
            mapped_res_r <= 32'sh7FFF_FFFF;
          end else if (sum < -35'sh0_8000_0000) begin
            mapped_res_r <= 32'sh8000_0000;
          end else begin
            mapped_res_r <= sum[31:0];
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_mapped_r <= mapped_res_r;
            out_low_rr   <= track_low_r;
            out_high_rr  <= track_high_r;
            out_drop_r   <= dropped_r;
            out_rose_r   <= rose_r;
            out_lvalid_r <= track_low_r < track_high_r;
            out_lon_r    <= learning_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mapped        = out_mapped_r;
  assign out_ch.learned_low   = out_low_rr;
  assign out_ch.learned_high  = out_high_rr;
  assign out_ch.low_dropped   = out_drop_r;
  assign out_ch.high_rose     = out_rose_r;
  assign out_ch.learned_valid = out_lvalid_r;
  assign out_ch.learning_on   = out_lon_r;

  // The sequencer only takes words while idle.
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");

  // The position in the range never exceeds one.
  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROD) |-> (curved_r <= Q_ONE)) else $error("curve above one");

  // A start op yields learning on and empty tracks; this checks learning on and a clear drop flag.
  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && op_r == OP_START) |-> learning_r && !dropped_r)
    else $error("start op state");

endmodule
